[design/mqttpr_pkg.sv]
// shared types and constants for the mqtt packet receiver
// used by the front parser, event queue, response back end and top level
`timescale 1ns / 1ps
`default_nettype none

package mqttpr_pkg;

  localparam int unsigned PKT_LEN_W   = 28;
  localparam int unsigned TOPIC_LEN_W = 16;
  localparam int unsigned EVQ_DEPTH   = 4;
  localparam int unsigned EVQ_PTR_W   = $clog2(EVQ_DEPTH);
  localparam int unsigned EVQ_CNT_W   = $clog2(EVQ_DEPTH + 1);

  localparam logic [PKT_LEN_W-1:0]   MAX_PKT_RESET   = 28'd4096;
  localparam logic [TOPIC_LEN_W-1:0] MAX_TOPIC_RESET = 16'd256;

  // control packet types
  localparam logic [3:0] T_CONNACK = 4'd2;
  localparam logic [3:0] T_PUBLISH = 4'd3;
  localparam logic [3:0] T_PUBACK  = 4'd4;
  localparam logic [3:0] T_PUBREC  = 4'd5;
  localparam logic [3:0] T_PUBREL  = 4'd6;
  localparam logic [3:0] T_PUBCOMP = 4'd7;

  // out_kind codes
  localparam logic [1:0] KIND_RESP = 2'd0;
  localparam logic [1:0] KIND_CONN = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_LEN_FIELD = 2'd0;
  localparam logic [1:0] ERR_PKT_LEN   = 2'd1;
  localparam logic [1:0] ERR_QOS       = 2'd2;
  localparam logic [1:0] ERR_TOPIC     = 2'd3;

  // register indexes
  localparam logic REG_MAX_PKT   = 1'b0;
  localparam logic REG_MAX_TOPIC = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_CONN,
    EV_ERR,
    EV_ANS
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [1:0]  code;
    logic [7:0]  head;
    logic [15:0] id;
  } event_t;

endpackage

`default_nettype wire

[design/mqttpr_front.sv]
// front parser: walks fixed header, length and body one byte per cycle while accept_i is high
// and classifies each byte into at most one event; needs mqttpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mqttpr_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire logic [7:0]                          rx_byte_i,
  input  wire logic [mqttpr_pkg::PKT_LEN_W-1:0]    max_pkt_i,
  input  wire logic [mqttpr_pkg::TOPIC_LEN_W-1:0]  max_topic_i,
  output mqttpr_pkg::event_t                       ev_o,
  output logic                                     halted_o
);
  import mqttpr_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_SKIP,
    PH_TOPIC_LEN_HI,
    PH_TOPIC_LEN_LO,
    PH_TOPIC,
    PH_ID_HI,
    PH_ID_LO,
    PH_PAYLOAD
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [3:0]             type_q, type_d;
  logic [1:0]             qos_q, qos_d;
  logic [1:0]             len_idx_q, len_idx_d;
  logic [PKT_LEN_W-1:0]   rem_q, rem_d;
  logic [PKT_LEN_W-1:0]   body_q, body_d;
  logic [TOPIC_LEN_W-1:0] topic_q, topic_d;
  logic [15:0]            id_q, id_d;
  logic [1:0]             skip_pos_q, skip_pos_d;
  logic                   halted_q, halted_d;
  event_t                 ev;

  function automatic event_t complete_ev(logic [3:0] ptype, logic [1:0] qos,
                                         logic [15:0] id);
    event_t e;
    e = '{kind: EV_NONE, code: 2'd0, head: 8'd0, id: id};
    unique case (ptype)
      T_CONNACK: e.kind = EV_CONN;
      T_PUBLISH: begin
        if (qos == 2'd1) begin
          e.kind = EV_ANS;
          e.head = {T_PUBACK, 4'h0};
        end else if (qos == 2'd2) begin
          e.kind = EV_ANS;
          e.head = {T_PUBREC, 4'h0};
        end
      end
      T_PUBREC: begin
        e.kind = EV_ANS;
        e.head = {T_PUBREL, 4'h2};
      end
      T_PUBREL: begin
        e.kind = EV_ANS;
        e.head = {T_PUBCOMP, 4'h0};
      end
      default: e.kind = EV_NONE;
    endcase
    return e;
  endfunction

  always_comb begin
    logic [PKT_LEN_W-1:0] rem_new;
    logic [PKT_LEN_W-1:0] body_dec;
    logic [15:0]          topic_new;
    logic [17:0]          need;
    logic                 failed;
    logic [1:0]           fail_code;

    phase_d    = phase_q;
    type_d     = type_q;
    qos_d      = qos_q;
    len_idx_d  = len_idx_q;
    rem_d      = rem_q;
    body_d     = body_q;
    topic_d    = topic_q;
    id_d       = id_q;
    skip_pos_d = skip_pos_q;
    halted_d   = halted_q;
    ev         = '{kind: EV_NONE, code: 2'd0, head: 8'd0, id: 16'd0};
    rem_new    = rem_q;
    body_dec   = body_q - PKT_LEN_W'(1);
    topic_new  = {topic_q[15:8], rx_byte_i};
    need       = {2'b00, topic_new} + 18'd2 + ((qos_q != 2'd0) ? 18'd2 : 18'd0);
    failed     = 1'b0;
    fail_code  = ERR_LEN_FIELD;

    if (accept_i && !halted_q) begin
      unique case (phase_q)
        PH_HEADER: begin
          type_d    = rx_byte_i[7:4];
          qos_d     = rx_byte_i[2:1];
          len_idx_d = 2'd0;
          rem_d     = '0;
          body_d    = '0;
          topic_d   = '0;
          id_d      = '0;
          phase_d   = PH_LENGTH;
        end
        PH_LENGTH: begin
          unique case (len_idx_q)
            2'd0: rem_new = rem_q | {21'd0, rx_byte_i[6:0]};
            2'd1: rem_new = rem_q | {14'd0, rx_byte_i[6:0], 7'd0};
            2'd2: rem_new = rem_q | {7'd0, rx_byte_i[6:0], 14'd0};
            2'd3: rem_new = rem_q | {rx_byte_i[6:0], 21'd0};
            default: rem_new = rem_q;
          endcase
          rem_d = rem_new;
          if (rx_byte_i[7]) begin
            if (len_idx_q == 2'd3) begin
              failed    = 1'b1;
              fail_code = ERR_LEN_FIELD;
            end else begin
              len_idx_d = len_idx_q + 2'd1;
            end
          end else if (rem_new > max_pkt_i) begin
            failed    = 1'b1;
            fail_code = ERR_PKT_LEN;
          end else if (type_q == T_PUBLISH && qos_q == 2'd3) begin
            failed    = 1'b1;
            fail_code = ERR_QOS;
          end else if (type_q == T_PUBLISH && rem_new < PKT_LEN_W'(2)) begin
            failed    = 1'b1;
            fail_code = ERR_TOPIC;
          end else begin
            phase_d    = (type_q == T_PUBLISH) ? PH_TOPIC_LEN_HI : PH_SKIP;
            body_d     = rem_new;
            skip_pos_d = 2'd0;
            // empty body completes on its last length byte
            if (rem_new == '0) begin
              phase_d = PH_HEADER;
              ev      = complete_ev(type_q, qos_q, id_q);
            end
          end
        end
        default: begin
          body_d = body_dec;
          unique case (phase_q)
            PH_SKIP: begin
              // first two body bytes carry the packet id
              if (skip_pos_q == 2'd0) begin
                id_d = {rx_byte_i, 8'h00};
              end else if (skip_pos_q == 2'd1) begin
                id_d = {id_q[15:8], rx_byte_i};
              end
              skip_pos_d = (skip_pos_q == 2'd2) ? 2'd2 : skip_pos_q + 2'd1;
            end
            PH_TOPIC_LEN_HI: begin
              topic_d = {rx_byte_i, 8'h00};
              phase_d = PH_TOPIC_LEN_LO;
            end
            PH_TOPIC_LEN_LO: begin
              topic_d = topic_new;
              if (topic_new >= max_topic_i || PKT_LEN_W'(need) > rem_q) begin
                failed    = 1'b1;
                fail_code = ERR_TOPIC;
              end else if (topic_new != '0) begin
                phase_d = PH_TOPIC;
              end else begin
                phase_d = (qos_q != 2'd0) ? PH_ID_HI : PH_PAYLOAD;
              end
            end
            PH_TOPIC: begin
              topic_d = topic_q - TOPIC_LEN_W'(1);
              if (topic_q == TOPIC_LEN_W'(1)) begin
                phase_d = (qos_q != 2'd0) ? PH_ID_HI : PH_PAYLOAD;
              end
            end
            PH_ID_HI: begin
              id_d    = {rx_byte_i, 8'h00};
              phase_d = PH_ID_LO;
            end
            PH_ID_LO: begin
              id_d    = {id_q[15:8], rx_byte_i};
              phase_d = PH_PAYLOAD;
            end
            default: ;
          endcase
          if (!failed && body_dec == '0) begin
            phase_d = PH_HEADER;
            ev      = complete_ev(type_q, qos_q, id_d);
          end
        end
      endcase

      if (failed) begin
        halted_d = 1'b1;
        phase_d  = PH_HEADER;
        ev       = '{kind: EV_ERR, code: fail_code, head: 8'd0, id: 16'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      type_q     <= '0;
      qos_q      <= '0;
      len_idx_q  <= '0;
      rem_q      <= '0;
      body_q     <= '0;
      topic_q    <= '0;
      id_q       <= '0;
      skip_pos_q <= '0;
      halted_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      type_q     <= type_d;
      qos_q      <= qos_d;
      len_idx_q  <= len_idx_d;
      rem_q      <= rem_d;
      body_q     <= body_d;
      topic_q    <= topic_d;
      id_q       <= id_d;
      skip_pos_q <= skip_pos_d;
      halted_q   <= halted_d;
    end
  end

  assign ev_o     = ev;
  assign halted_o = halted_q;

endmodule

`default_nettype wire

[design/mqttpr_evq.sv]
// short event queue between front parser and response back end
// depth from mqttpr_pkg; registered write, first-word read
`timescale 1ns / 1ps
`default_nettype none

module mqttpr_evq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire mqttpr_pkg::event_t  wr_data_i,
  input  wire logic                rd_en_i,
  output mqttpr_pkg::event_t       rd_data_o,
  output logic                     full_o,
  output logic                     empty_o
);
  import mqttpr_pkg::*;

  event_t               mem_q [EVQ_DEPTH];
  logic [EVQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [EVQ_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + EVQ_CNT_W'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - EVQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + EVQ_PTR_W'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + EVQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign full_o    = (cnt_q == EVQ_CNT_W'(EVQ_DEPTH));
  assign empty_o   = (cnt_q == '0);

endmodule

`default_nettype wire

[design/mqttpr_back.sv]
// response back end: takes events from the queue and plays them out
// as result beats, four for an answer packet; needs mqttpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module mqttpr_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               evq_empty_i,
  input  wire mqttpr_pkg::event_t evq_data_i,
  output logic                    evq_rd_o,
  input  wire logic               pop_acc_i,
  output logic                    valid_o,
  output logic [1:0]              out_kind_o,
  output logic [7:0]              out_byte_o,
  output logic [1:0]              error_code_o,
  output logic                    last_o
);
  import mqttpr_pkg::*;

  event_t     cur_q;
  logic [1:0] beat_q;
  logic       valid_q;
  logic       final_beat;
  logic       take;
  logic       load;

  assign final_beat = (cur_q.kind != EV_ANS) || (beat_q == 2'd3);
  // output stage frees up on the pop of its final beat
  assign take       = valid_q ? (pop_acc_i && final_beat) : 1'b1;
  assign load       = take && !evq_empty_i;
  assign evq_rd_o   = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      beat_q  <= '0;
    end else if (pop_acc_i) begin
      if (final_beat) begin
        valid_q <= 1'b0;
      end else begin
        beat_q <= beat_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= evq_data_i;
    end
  end

  always_comb begin
    out_byte_o   = 8'd0;
    error_code_o = 2'd0;
    unique case (cur_q.kind)
      EV_ANS: begin
        out_kind_o = KIND_RESP;
        unique case (beat_q)
          2'd0: out_byte_o = cur_q.head;
          2'd1: out_byte_o = 8'h02;
          2'd2: out_byte_o = cur_q.id[15:8];
          2'd3: out_byte_o = cur_q.id[7:0];
          default: out_byte_o = 8'd0;
        endcase
      end
      EV_CONN: out_kind_o = KIND_CONN;
      default: begin
        out_kind_o   = KIND_ERR;
        error_code_o = cur_q.code;
      end
    endcase
  end

  assign valid_o = valid_q;
  assign last_o  = final_beat;

endmodule

`default_nettype wire

[design/mqtt_packet_receiver.sv]
// mqtt control packet receiver: one received byte per cycle, no stall on its own;
// a result reaches the output through the event queue and the back end's output register when nothing waits.
// an answer takes 4 output beats; the event queue holds 4 events, and push stalls
// (full high) only while it is full.
// reset: limits go to 4096 and 256, parser expects a fixed header, halt flag and queue clear.
// top level: config registers, front parser, event queue and response back end
`timescale 1ns / 1ps
`default_nettype none

module mqtt_packet_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       error_code_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mqttpr_pkg::*;

  logic [PKT_LEN_W-1:0]   max_pkt_q;
  logic [TOPIC_LEN_W-1:0] max_topic_q;
  logic                   cfg_wr;
  logic                   in_acc;
  logic                   out_acc;
  event_t                 front_ev;
  event_t                 evq_data;
  logic                   evq_full;
  logic                   evq_empty;
  logic                   evq_rd;
  logic                   out_valid;
  logic                   halted;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q   <= MAX_PKT_RESET;
      max_topic_q <= MAX_TOPIC_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_PKT:   max_pkt_q   <= pwdata[PKT_LEN_W-1:0];
        REG_MAX_TOPIC: max_topic_q <= pwdata[TOPIC_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_PKT:   prdata = {{(32-PKT_LEN_W){1'b0}}, max_pkt_q};
      REG_MAX_TOPIC: prdata = {{(32-TOPIC_LEN_W){1'b0}}, max_topic_q};
      default:       prdata = '0;
    endcase
  end

  assign full    = evq_full;
  assign in_acc  = push && !full;
  assign empty   = !out_valid;
  assign out_acc = pop && !empty;

  mqttpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .rx_byte_i   (rx_byte_i),
    .max_pkt_i   (max_pkt_q),
    .max_topic_i (max_topic_q),
    .ev_o        (front_ev),
    .halted_o    (halted)
  );

  mqttpr_evq u_evq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (front_ev.kind != EV_NONE),
    .wr_data_i (front_ev),
    .rd_en_i   (evq_rd),
    .rd_data_o (evq_data),
    .full_o    (evq_full),
    .empty_o   (evq_empty)
  );

  mqttpr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evq_empty_i  (evq_empty),
    .evq_data_i   (evq_data),
    .evq_rd_o     (evq_rd),
    .pop_acc_i    (out_acc),
    .valid_o      (out_valid),
    .out_kind_o   (out_kind_o),
    .out_byte_o   (out_byte_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  // single-beat results always close their group
  a_single_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_kind_o != KIND_RESP) |-> last_o)
    else $error("connack or error beat without last");

  a_code_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_kind_o != KIND_ERR) |-> (error_code_o == ERR_LEN_FIELD))
    else $error("error code set on a non-error beat");

  // once halted, the parser stays halted and emits nothing further
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted |=> (halted && front_ev.kind == EV_NONE))
    else $error("parser left halt or produced an event");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evq_full |-> (front_ev.kind == EV_NONE))
    else $error("event produced while queue full");

endmodule

`default_nettype wire
